/* hdl/fbcr_pkg.sv */
// Shared constants and types for the FSK bit clock recovery block.
package fbcr_pkg;

    // Loop gains are unsigned Q0.16
    localparam int GAIN_BITS = 16;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_NOMINAL_STEP = 2'd0;
    localparam t_cfg_idx CFG_PHASE_GAIN   = 2'd1;
    localparam t_cfg_idx CFG_FREQ_GAIN    = 2'd2;

    // Gain reset values: 0.15 and 0.005 in Q0.16
    localparam logic [GAIN_BITS-1:0] PHASE_GAIN_RESET = 16'd9830;
    localparam logic [GAIN_BITS-1:0] FREQ_GAIN_RESET  = 16'd328;

endpackage

/* hdl/fbcr_loop.sv */
// Second-order clock loop update: phase advance, crossing correction, step clamp and wrap.
module fbcr_loop import fbcr_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  logic signed [FRAC_BITS+2:0] i_phase,      // current phase, Q2.F, in [0, 1)
    input  logic        [FRAC_BITS:0]   i_step,       // current step, Q1.F
    input  logic        [GAIN_BITS-1:0] i_phase_gain,
    input  logic        [GAIN_BITS-1:0] i_freq_gain,
    input  logic                        i_crossing,
    output logic signed [FRAC_BITS+2:0] o_phase,
    output logic        [FRAC_BITS:0]   o_step,
    output logic                        o_emit
);

    localparam int PW  = FRAC_BITS + 3;
    localparam int SW  = FRAC_BITS + 1;
    localparam int MW  = FRAC_BITS + 1;
    localparam int PRW = MW + GAIN_BITS;

    localparam logic signed [PW-1:0] HALF_S = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] ONE_S  = PW'(1) << FRAC_BITS;
    localparam logic signed [PW-1:0] LSB_S  = PW'(1);

    logic signed [PW-1:0]  phase_add;
    logic signed [PW-1:0]  err;
    logic signed [PW-1:0]  err_abs;
    logic                  err_neg;
    logic        [MW-1:0]  mag;
    logic        [PRW-1:0] prod_p;
    logic        [PRW-1:0] prod_f;
    logic signed [PW-1:0]  corr_p;
    logic signed [PW-1:0]  corr_f;
    logic signed [PW-1:0]  phase_c;
    logic signed [PW-1:0]  step_s;

    // Advance, then measure the error against one half
    assign phase_add = i_phase + $signed({2'b00, i_step});
    assign err       = phase_add - HALF_S;
    assign err_neg   = err[PW-1];
    assign err_abs   = err_neg ? -err : err;
    // |err| < 1.5, so it fits in Q1.F
    assign mag       = err_abs[MW-1:0];

    // Corrections truncate toward zero on the magnitude
    assign prod_p = PRW'(mag) * PRW'(i_phase_gain);
    assign prod_f = PRW'(mag) * PRW'(i_freq_gain);
    assign corr_p = $signed({2'b00, prod_p[PRW-1:GAIN_BITS]});
    assign corr_f = $signed({2'b00, prod_f[PRW-1:GAIN_BITS]});

    always_comb begin
        phase_c = phase_add;
        step_s  = $signed({2'b00, i_step});
        if (i_crossing) begin
            phase_c = err_neg ? phase_add + corr_p : phase_add - corr_p;
            step_s  = err_neg ? step_s + corr_f : step_s - corr_f;
        end

        // Step stays between one LSB and 1.0
        if (step_s < LSB_S) begin
            o_step = SW'(1);
        end else if (step_s > ONE_S) begin
            o_step = ONE_S[SW-1:0];
        end else begin
            o_step = step_s[SW-1:0];
        end

        // Phase stays in [0, 2) after correction; wrap at 1.0 and emit a bit
        o_emit  = (phase_c >= ONE_S);
        o_phase = o_emit ? phase_c - ONE_S : phase_c;
    end

endmodule

/* hdl/fsk_bit_clock_recovery.sv */
// Top level of the FSK bit clock recovery block: handshakes, state and result register.
//
//  channel  dir  handshake              payload
//  s        in   i_s_tvalid/o_s_tready  tdata: sample; tlast: block_end
//  m        out  o_m_tvalid/i_m_tready  tdata: bit_res
//  cfg      in   i_cfg_valid/o_cfg_ready index, data
//
// One sample per cycle sustained while the result side is not stalled; an emitted bit is
// offered once its sample has passed the sample register and then the result register.
// The per-sample loop update (add, one multiply per gain, subtract, clamp) is a
// combinational path between the sample register and the state/result registers.
// Synchronous active-low reset loads the nominal step and default gains, clears phase.
// A stalled result holds the sample register; the input is still taken while it is empty.
module fsk_bit_clock_recovery import fbcr_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata: sample [SAMPLE_BITS-1:0], zero padded to bytes
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] i_s_tdata,
    input  logic                                 i_s_tlast,   // block_end
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: bit_res [0], zero padded to a byte
    output logic [7:0]                           o_m_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  t_cfg_idx                             i_cfg_index,
    input  logic [FRAC_BITS:0]                   i_cfg_data
);

    localparam int PW = FRAC_BITS + 3;
    localparam int SW = FRAC_BITS + 1;

    localparam logic [SW-1:0]        ONE_STEP    = SW'(1) << FRAC_BITS;
    localparam logic [SW-1:0]        NOM_RESET   = SW'(1) << (FRAC_BITS - 2);
    localparam logic signed [PW-1:0] ONE_PHASE_S = PW'(1) << FRAC_BITS;

    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [PW-1:0]          r_phase;
    logic [SW-1:0]                 r_step;
    logic                          r_prev_pos;
    logic [GAIN_BITS-1:0]          r_phase_gain;
    logic [GAIN_BITS-1:0]          r_freq_gain;
    logic                          r_out_valid;
    logic                          r_out_bit;

    logic                          out_free;
    logic                          adv;
    logic                          cur_pos;
    logic                          crossing;
    logic                          cfg_wr;
    logic [SW-1:0]                 n_cfg_step;
    logic signed [PW-1:0]          n_phase;
    logic [SW-1:0]                 n_step;
    logic                          emit;

    // Flow control: the held sample moves on when the result slot is free
    assign out_free   = !r_out_valid || i_m_tready;
    assign adv        = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_bit};

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // Zero counts as the negative side for crossings
    assign cur_pos  = !r_sample[SAMPLE_BITS-1] && (r_sample != '0);
    assign crossing = cur_pos ^ r_prev_pos;

    // Nominal step written from the port is clamped to [1 LSB, 1.0]
    always_comb begin
        if (i_cfg_data == '0) begin
            n_cfg_step = SW'(1);
        end else if (i_cfg_data > ONE_STEP) begin
            n_cfg_step = ONE_STEP;
        end else begin
            n_cfg_step = i_cfg_data;
        end
    end

    fbcr_loop #(
        .FRAC_BITS (FRAC_BITS)
    ) u_loop (
        .i_phase      (r_phase),
        .i_step       (r_step),
        .i_phase_gain (r_phase_gain),
        .i_freq_gain  (r_freq_gain),
        .i_crossing   (crossing),
        .o_phase      (n_phase),
        .o_step       (n_step),
        .o_emit       (emit)
    );

    // Sample register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_sample <= i_s_tdata[SAMPLE_BITS-1:0];
        end
    end

    // Loop state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_step       <= NOM_RESET;
            r_prev_pos   <= 1'b0;
            r_phase_gain <= PHASE_GAIN_RESET;
            r_freq_gain  <= FREQ_GAIN_RESET;
        end else begin
            if (adv) begin
                r_phase    <= n_phase;
                r_prev_pos <= cur_pos;
            end
            // A nominal step write reloads the step ahead of the loop update
            if (cfg_wr && (i_cfg_index == CFG_NOMINAL_STEP)) begin
                r_step <= n_cfg_step;
            end else if (adv) begin
                r_step <= n_step;
            end
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_PHASE_GAIN: r_phase_gain <= i_cfg_data[GAIN_BITS-1:0];
                    CFG_FREQ_GAIN:  r_freq_gain  <= i_cfg_data[GAIN_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_out_bit <= !r_sample[SAMPLE_BITS-1];
        end
    end

`ifndef SYNTH
    // Step never leaves [1 LSB, 1.0]
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != '0) && (r_step <= ONE_STEP))
        else $error("clock step out of range");

    // Stored phase is always wrapped into [0, 1)
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase >= 0) && (r_phase < ONE_PHASE_S))
        else $error("clock phase out of range");

    // A waiting result is never overwritten by a new sample
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !adv)
        else $error("pending result overwritten");
`endif

endmodule
